// ===== rtl/eauv_pkg.sv =====
// ----------------------------------------------------------------------------
// eauv_pkg
// Shared types and constants for the encoder angle unwrap and velocity block.
// ----------------------------------------------------------------------------
package eauv_pkg;

    // Single-turn angle resolution; one turn is 2**ANGLE_BITS counts
    localparam int ANGLE_BITS = 12;

    // Field and register widths
    localparam int BYTE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int TURN_W     = 32;
    localparam int VEL_W      = 32;
    localparam int WRAP_W     = 12;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Angle compare width, wide enough for a change magnitude and the threshold
    localparam int CMP_W = (ANGLE_BITS + 1 > WRAP_W) ? ANGLE_BITS + 1 : WRAP_W;

    // Velocity scaling: counts per microsecond to counts per second.
    // The scale is split into an odd factor (serial multiply) and a shift.
    localparam int unsigned VEL_SCALE = 1000000;
    localparam int MUL_SHIFT          = 6;
    localparam int unsigned MUL_K     = VEL_SCALE >> MUL_SHIFT;
    localparam int MUL_BITS           = $clog2(MUL_K + 1);
    localparam int MUL_IDX_W          = $clog2(MUL_BITS);
    localparam int SCALE_W            = $clog2(VEL_SCALE + 1);
    localparam logic [MUL_BITS-1:0] MUL_K_BITS = MUL_BITS'(MUL_K);

    // Delta magnitude width and datapath width of the shared adder
    localparam int MAG_W = TURN_W + 1 + ANGLE_BITS + 1;
    localparam int ACC_W = MAG_W + SCALE_W;

    // Restoring divider: one quotient bit per step
    localparam int DIV_STEPS = VEL_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    // Reset values of the configuration registers
    localparam logic [WRAP_W-1:0]     WRAP_RESET     = WRAP_W'(3276);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);

    // Operation codes
    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_VELOCITY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_INTERVAL = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DT,
        ST_TDIFF,
        ST_DELTA,
        ST_ABS,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_NEG,
        ST_FINISH
    } state_t;

    typedef struct packed {
        state_t           state;
        logic [CNT_W-1:0] cnt;
        logic             ready;
    } ctrl_t;

endpackage

// ===== rtl/eauv_if.sv =====
// ----------------------------------------------------------------------------
// eauv_if
// Valid/ready channels of the encoder unwrap block: samples, results, config.
// ----------------------------------------------------------------------------
interface eauv_in_if
    import eauv_pkg::*;
();

    logic              valid;
    logic              ready;
    logic              operation;
    logic              read_ok;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] angle_high_byte;
    logic [BYTE_W-1:0] angle_low_byte;
    logic [BYTE_W-1:0] gain_byte;
    logic [TIME_W-1:0] timestamp_us;

    modport source (
        output valid, operation, read_ok, status_byte, angle_high_byte,
               angle_low_byte, gain_byte, timestamp_us,
        input  ready
    );

    modport sink (
        input  valid, operation, read_ok, status_byte, angle_high_byte,
               angle_low_byte, gain_byte, timestamp_us,
        output ready
    );
endinterface

interface eauv_out_if
    import eauv_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic [ANGLE_BITS-1:0]    angle_counts;
    logic signed [TURN_W-1:0] turn_count;
    logic signed [VEL_W-1:0]  velocity_cps;
    logic [BYTE_W-1:0]        good_status;
    logic [BYTE_W-1:0]        last_gain;
    logic                     diag_valid;

    modport source (
        output valid, angle_counts, turn_count, velocity_cps, good_status,
               last_gain, diag_valid,
        input  ready
    );

    modport sink (
        input  valid, angle_counts, turn_count, velocity_cps, good_status,
               last_gain, diag_valid,
        output ready
    );
endinterface

interface eauv_cfg_if
    import eauv_pkg::*;
();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/encoder_angle_unwrap_velocity.sv =====
// ----------------------------------------------------------------------------
// encoder_angle_unwrap_velocity
// Multi-turn unwrap and velocity estimate for a 12-bit absolute angle sensor.
// ----------------------------------------------------------------------------
// A sample item updates the tracked state when taken; its result goes through
// FINISH into the result register. A velocity item runs setup steps (elapsed
// time, turn difference, count delta, magnitude), 14 shift-and-add steps that
// scale the count delta to counts per second, one range check and 32 restoring
// divide steps by the elapsed time, all on one shared 66-bit adder. The block
// takes no new item while it computes, but it does take one while a finished
// result is still waiting at the output. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module encoder_angle_unwrap_velocity
    import eauv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    eauv_in_if.sink    sample,
    eauv_out_if.source result,
    eauv_cfg_if.sink   cfg
);

    ctrl_t ctrl;
    logic  accept;
    logic  out_free;
    logic  out_load;

    // Configuration
    logic [WRAP_W-1:0]     wrap_thr_reg;
    logic [INTERVAL_W-1:0] def_int_reg;

    // Tracked state
    logic [ANGLE_BITS-1:0] cur_angle_reg;
    logic [TURN_W-1:0]     turns_reg;
    logic [TIME_W-1:0]     sample_time_reg;
    logic [ANGLE_BITS-1:0] ref_angle_reg;
    logic [TURN_W-1:0]     ref_turns_reg;
    logic [TIME_W-1:0]     ref_time_reg;
    logic [BYTE_W-1:0]     held_status_reg;
    logic [BYTE_W-1:0]     held_gain_reg;
    logic                  valid_flag_reg;
    logic                  primed_reg;

    // Velocity datapath
    logic [TIME_W-1:0] dt_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  mcand_reg;
    logic              neg_reg;
    logic              sat_reg;
    logic [VEL_W-1:0]  rem_reg;
    logic [VEL_W-1:0]  quo_reg;
    logic [VEL_W-1:0]  vel_reg;

    // Result register
    logic                  out_valid_reg;
    logic [ANGLE_BITS-1:0] out_angle_reg;
    logic [TURN_W-1:0]     out_turns_reg;
    logic [VEL_W-1:0]      out_vel_reg;
    logic [BYTE_W-1:0]     out_status_reg;
    logic [BYTE_W-1:0]     out_gain_reg;
    logic                  out_diag_reg;

    // Sample update
    logic [ANGLE_BITS-1:0]   dec_angle;
    logic [ANGLE_BITS-1:0]   new_angle;
    logic [ANGLE_BITS:0]     ang_diff;
    logic [ANGLE_BITS:0]     ang_mag;
    logic                    do_wrap;
    logic [TURN_W-1:0]       turns_step;

    // Shared unit
    logic [ACC_W-1:0] alu_a;
    logic [ACC_W-1:0] alu_b;
    logic             alu_sub;
    logic [ACC_W-1:0] alu_sum;
    logic             alu_carry;

    logic [ANGLE_BITS:0] dang;
    logic [ACC_W-1:0]    scaled;
    logic [TIME_W-1:0]   dt_raw;
    logic                big;

    assign accept   = sample.valid && ctrl.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign out_load = (ctrl.state == ST_FINISH) && out_free;

    assign sample.ready = ctrl.ready;
    assign cfg.ready    = 1'b1;

    eauv_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (sample.operation),
        .out_free  (out_free),
        .ctrl      (ctrl)
    );

    eauv_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // ---- Sample decode and wrap detection --------------------------------
    assign dec_angle  = {sample.angle_high_byte[ANGLE_BITS-9:0], sample.angle_low_byte};
    assign new_angle  = sample.read_ok ? dec_angle : cur_angle_reg;
    assign ang_diff   = {1'b0, new_angle} - {1'b0, cur_angle_reg};
    assign ang_mag    = ang_diff[ANGLE_BITS] ? (~ang_diff + 1'b1) : ang_diff;
    assign do_wrap    = CMP_W'(ang_mag) > CMP_W'(wrap_thr_reg);
    // A rise past the threshold is a backward wrap
    assign turns_step = ang_diff[ANGLE_BITS] ? TURN_W'(1) : {TURN_W{1'b1}};

    // ---- Shared unit operand select --------------------------------------
    assign dang   = {1'b0, cur_angle_reg} - {1'b0, ref_angle_reg};
    assign scaled = acc_reg << MUL_SHIFT;
    assign dt_raw = alu_sum[TIME_W-1:0];
    assign big    = sat_reg || quo_reg[VEL_W-1];

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (ctrl.state)
            ST_DT:
            begin
                alu_a = ACC_W'(sample_time_reg);
                alu_b = ACC_W'(ref_time_reg);
            end
            ST_TDIFF:
            begin
                alu_a = {{(ACC_W-TURN_W){turns_reg[TURN_W-1]}}, turns_reg};
                alu_b = {{(ACC_W-TURN_W){ref_turns_reg[TURN_W-1]}}, ref_turns_reg};
            end
            ST_DELTA:
            begin
                alu_a   = acc_reg << ANGLE_BITS;
                alu_b   = {{(ACC_W-ANGLE_BITS-1){dang[ANGLE_BITS]}}, dang};
                alu_sub = 1'b0;
            end
            ST_ABS:
            begin
                alu_b = acc_reg;
            end
            ST_MUL:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b0;
            end
            ST_CHECK:
            begin
                alu_a = ACC_W'(scaled[ACC_W-1:VEL_W]);
                alu_b = ACC_W'(dt_reg);
            end
            ST_DIV:
            begin
                alu_a = ACC_W'({rem_reg, quo_reg[VEL_W-1]});
                alu_b = ACC_W'(dt_reg);
            end
            ST_NEG:
            begin
                alu_b = ACC_W'(quo_reg);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // ---- Configuration ---------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_thr_reg <= WRAP_RESET;
            def_int_reg  <= INTERVAL_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WRAP_THRESHOLD:   wrap_thr_reg <= cfg.data[WRAP_W-1:0];
                REG_DEFAULT_INTERVAL: def_int_reg  <= cfg.data[INTERVAL_W-1:0];
                default:              wrap_thr_reg <= wrap_thr_reg;
            endcase
        end
    end

    // ---- Tracked state ---------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_angle_reg   <= '0;
            turns_reg       <= '0;
            sample_time_reg <= '0;
            ref_angle_reg   <= '0;
            ref_turns_reg   <= '0;
            ref_time_reg    <= '0;
            held_status_reg <= '0;
            held_gain_reg   <= '0;
            valid_flag_reg  <= 1'b0;
            primed_reg      <= 1'b0;
        end
        else if (accept && sample.operation == OP_SAMPLE)
        begin
            valid_flag_reg  <= sample.read_ok;
            sample_time_reg <= sample.timestamp_us;
            cur_angle_reg   <= new_angle;
            if (sample.read_ok)
            begin
                held_status_reg <= sample.status_byte;
                held_gain_reg   <= sample.gain_byte;
            end
            if (!primed_reg)
            begin
                // First sample only seeds the reference
                ref_angle_reg <= new_angle;
                ref_time_reg  <= sample.timestamp_us;
                turns_reg     <= '0;
                ref_turns_reg <= '0;
                primed_reg    <= 1'b1;
            end
            else if (do_wrap)
            begin
                turns_reg <= turns_reg + turns_step;
            end
        end
        else if (ctrl.state == ST_NEG)
        begin
            // Move the velocity reference to now
            ref_angle_reg <= cur_angle_reg;
            ref_turns_reg <= turns_reg;
            ref_time_reg  <= sample_time_reg;
        end
    end

    // ---- Velocity datapath -----------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept && sample.operation == OP_SAMPLE)
            vel_reg <= '0;

        case (ctrl.state)
            ST_DT:
            begin
                // Zero elapsed time falls back to the default interval, or to 1 if that is zero
                if (dt_raw != '0)
                    dt_reg <= dt_raw;
                else if (def_int_reg != '0)
                    dt_reg <= TIME_W'(def_int_reg);
                else
                    dt_reg <= TIME_W'(1);
            end
            ST_TDIFF, ST_DELTA:
            begin
                acc_reg <= alu_sum;
            end
            ST_ABS:
            begin
                neg_reg   <= acc_reg[ACC_W-1];
                mcand_reg <= acc_reg[ACC_W-1] ? alu_sum : acc_reg;
                acc_reg   <= '0;
            end
            ST_MUL:
            begin
                if (MUL_K_BITS[ctrl.cnt[MUL_IDX_W-1:0]])
                    acc_reg <= alu_sum;
                mcand_reg <= mcand_reg << 1;
            end
            ST_CHECK:
            begin
                // Quotient of 2**32 or more saturates regardless
                sat_reg <= alu_carry;
                rem_reg <= scaled[2*VEL_W-1:VEL_W];
                quo_reg <= scaled[VEL_W-1:0];
            end
            ST_DIV:
            begin
                quo_reg <= {quo_reg[VEL_W-2:0], alu_carry};
                rem_reg <= alu_carry ? alu_sum[VEL_W-1:0]
                                     : {rem_reg[VEL_W-2:0], quo_reg[VEL_W-1]};
            end
            ST_NEG:
            begin
                if (neg_reg)
                    vel_reg <= big ? VEL_MIN : alu_sum[VEL_W-1:0];
                else
                    vel_reg <= big ? VEL_MAX : quo_reg;
            end
            default:
            begin
                dt_reg <= dt_reg;
            end
        endcase
    end

    // ---- Result register -------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_angle_reg  <= cur_angle_reg;
            out_turns_reg  <= turns_reg;
            out_vel_reg    <= vel_reg;
            out_status_reg <= held_status_reg;
            out_gain_reg   <= held_gain_reg;
            out_diag_reg   <= valid_flag_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.angle_counts = out_angle_reg;
    assign result.turn_count   = $signed(out_turns_reg);
    assign result.velocity_cps = $signed(out_vel_reg);
    assign result.good_status  = out_status_reg;
    assign result.last_gain    = out_gain_reg;
    assign result.diag_valid   = out_diag_reg;

endmodule

// ===== rtl/eauv_alu.sv =====
// ----------------------------------------------------------------------------
// eauv_alu
// Shared adder/subtractor; carry out on subtract means a >= b (unsigned).
// ----------------------------------------------------------------------------
module eauv_alu
    import eauv_pkg::*;
(
    input  logic [ACC_W-1:0] a,
    input  logic [ACC_W-1:0] b,
    input  logic             sub,
    output logic [ACC_W-1:0] sum,
    output logic             carry
);

    logic [ACC_W-1:0] b_in;

    assign b_in = sub ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_in} + (ACC_W + 1)'(sub);

endmodule

// ===== rtl/eauv_seq.sv =====
// ----------------------------------------------------------------------------
// eauv_seq
// Sequencer for sample and velocity items: setup, serial multiply, check, divide.
// ----------------------------------------------------------------------------
module eauv_seq
    import eauv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  logic  operation,
    input  logic  out_free,
    output ctrl_t ctrl
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (operation == OP_VELOCITY) ? ST_DT : ST_FINISH;
            end
            ST_DT:    state_next = ST_TDIFF;
            ST_TDIFF: state_next = ST_DELTA;
            ST_DELTA: state_next = ST_ABS;
            ST_ABS:
            begin
                state_next = ST_MUL;
                cnt_next   = '0;
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_BITS - 1))
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_NEG;
            end
            ST_NEG: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.state = state_reg;
        ctrl.cnt   = cnt_reg;
        ctrl.ready = (state_reg == ST_IDLE);
    end

endmodule
